>>> sv/utf_string_decoder_macros.svh
`ifndef UTF_STRING_DECODER_MACROS_SVH
`define UTF_STRING_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define USD_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("usd assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off while rst is high.
`define USD_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("usd assertion failed: next-cycle check");

`endif

>>> sv/usd_pkg.sv
package usd_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 31;
  localparam int OWED_W  = 3;
  localparam int LEAD_PAYLOAD_W = 5;

  typedef enum logic [1:0] {
    KIND_LENGTH = 2'd0,
    KIND_CODE   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic                      valid;
    logic                      ascii;
    logic [OWED_W-1:0]         extra;
    logic [LEAD_PAYLOAD_W-1:0] payload;
  } lead_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } res_t;

endpackage

>>> sv/usd_if.sv
interface usd_byte_if import usd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface usd_item_if import usd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         item_kind;
  logic [VALUE_W-1:0] code_value;
  logic               last_of_string;

  modport source (output valid, output item_kind, output code_value, output last_of_string,
                  input ready);
  modport sink   (input valid, input item_kind, input code_value, input last_of_string,
                  output ready);
endinterface

>>> sv/usd_lead_decode.sv
module usd_lead_decode import usd_pkg::*; (
  input  logic [BYTE_W-1:0] byte_in,
  output lead_t             lead
);

  localparam logic [2:0] LEAD_TWO   = 3'b110;
  localparam logic [3:0] LEAD_THREE = 4'b1110;
  localparam logic [4:0] LEAD_FOUR  = 5'b11110;
  localparam logic [5:0] LEAD_FIVE  = 6'b111110;
  localparam logic [6:0] LEAD_SIX   = 7'b1111110;

  always_comb begin
    lead = '0;
    priority if (!byte_in[7]) begin
      lead.valid = 1'b1;
      lead.ascii = 1'b1;
    end else if (byte_in[7:5] == LEAD_TWO) begin
      lead.valid   = 1'b1;
      lead.extra   = 3'd1;
      lead.payload = byte_in[4:0];
    end else if (byte_in[7:4] == LEAD_THREE) begin
      lead.valid   = 1'b1;
      lead.extra   = 3'd2;
      lead.payload = {1'b0, byte_in[3:0]};
    end else if (byte_in[7:3] == LEAD_FOUR) begin
      lead.valid   = 1'b1;
      lead.extra   = 3'd3;
      lead.payload = {2'b0, byte_in[2:0]};
    end else if (byte_in[7:2] == LEAD_FIVE) begin
      lead.valid   = 1'b1;
      lead.extra   = 3'd4;
      lead.payload = {3'b0, byte_in[1:0]};
    end else if (byte_in[7:1] == LEAD_SIX) begin
      lead.valid   = 1'b1;
      lead.extra   = 3'd5;
      lead.payload = {4'b0, byte_in[0]};
    end else begin
      lead = '0;
    end
  end

endmodule

>>> sv/usd_core.sv
`include "utf_string_decoder_macros.svh"

module usd_core import usd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [BYTE_W-1:0] byte_in,
  input  lead_t             lead,
  output res_t              res
);

  logic               phase, phase_next;
  logic [OWED_W-1:0]  owed, owed_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic [VALUE_W-1:0] chars, chars_next;
  logic [VALUE_W-1:0] acc_shift, chars_dec, fin_value;
  logic               fin;

  always_comb begin
    phase_next = phase;
    owed_next  = owed;
    acc_next   = acc;
    chars_next = chars;
    fin        = 1'b0;
    fin_value  = '0;
    res        = '0;
    acc_shift  = {acc[VALUE_W-7:0], byte_in[5:0]};
    chars_dec  = (chars != '0) ? chars - VALUE_W'(1) : chars;

    if (owed != '0) begin
      acc_next  = acc_shift;
      owed_next = owed - OWED_W'(1);
      if (owed == OWED_W'(1)) begin
        fin       = 1'b1;
        fin_value = acc_shift;
      end
    end else if (lead.ascii) begin
      fin       = 1'b1;
      fin_value = {{(VALUE_W-7){1'b0}}, byte_in[6:0]};
    end else if (lead.valid) begin
      acc_next  = {{(VALUE_W-LEAD_PAYLOAD_W){1'b0}}, lead.payload};
      owed_next = lead.extra;
    end else begin
      phase_next = 1'b0;
      chars_next = '0;
      acc_next   = '0;
      owed_next  = '0;
      res.valid  = 1'b1;
      res.kind   = KIND_ERROR;
      res.value  = '0;
      res.last   = 1'b1;
    end

    if (fin) begin
      acc_next  = '0;
      res.valid = 1'b1;
      res.value = fin_value;
      if (!phase) begin
        res.kind = KIND_LENGTH;
        if (fin_value == '0) begin
          res.last = 1'b1;
        end else begin
          chars_next = fin_value;
          phase_next = 1'b1;
        end
      end else begin
        res.kind   = KIND_CODE;
        chars_next = chars_dec;
        if (chars_dec == '0) begin
          phase_next = 1'b0;
          res.last   = 1'b1;
        end
      end
    end

    if (!accept) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      owed  <= '0;
      acc   <= '0;
      chars <= '0;
    end else if (accept) begin
      phase <= phase_next;
      owed  <= owed_next;
      acc   <= acc_next;
      chars <= chars_next;
    end
  end

  `USD_ASSERT_NOW(a_phase_tracks_chars, 1'b1, phase == (chars != '0))
  `USD_ASSERT_NOW(a_error_only_at_lead, res.valid && res.kind == KIND_ERROR, owed == '0)
  `USD_ASSERT_NEXT(a_owed_counts_down, accept && owed != '0,
                   owed == $past(owed) - OWED_W'(1))

endmodule

>>> sv/usd_out_buf.sv
`include "utf_string_decoder_macros.svh"

module usd_out_buf import usd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  res_t res,
  output logic in_ready,
  usd_item_if.source item_chan
);

  logic main_valid, skid_valid;
  res_t main_data, skid_data;
  logic pop, push;

  assign in_ready = !skid_valid;
  assign pop      = main_valid && item_chan.ready;
  assign push     = res.valid;

  assign item_chan.valid          = main_valid;
  assign item_chan.item_kind      = main_data.kind;
  assign item_chan.code_value     = main_data.value;
  assign item_chan.last_of_string = main_data.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
        main_data  <= res;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
        main_data  <= res;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= res;
      end
    end
  end

  `USD_ASSERT_NOW(a_skid_needs_main, skid_valid, main_valid)
  `USD_ASSERT_NEXT(a_stall_fills_skid, push && main_valid && !pop, skid_valid)
  `USD_ASSERT_NEXT(a_main_holds, main_valid && !pop, main_valid && $stable(main_data))

endmodule

>>> sv/utf_string_decoder.sv
// Decodes a byte stream of length-prefixed strings, one byte per cycle. Each string is a
// UTF-8 style length code of 1 to 6 bytes (up to 31 bits) followed by that many code points
// in the same coding; the block emits the length (item_kind 0), then each code point
// (item_kind 1), with last_of_string set on the final item of a string and on a zero
// length. A lead byte of 0x80-0xBF, 0xFE or 0xFF gives item_kind 2 with value 0 and last
// set, drops the string and reads the next byte as a new header. Continuation bytes give
// their low six bits unchecked; overlong codes pass. Throughput is one byte per cycle
// while ready is high, set by the single decode step between the byte port and the
// result register; each result is registered in a two-entry output buffer that keeps
// bytes flowing while a result waits, so ready drops only when both entries are full.
module utf_string_decoder import usd_pkg::*; (
  input  logic clk,
  input  logic rst,
  usd_byte_if.sink   byte_chan,
  usd_item_if.source item_chan
);

  lead_t lead;
  res_t  res;
  logic  in_ready;
  logic  accept;

  assign byte_chan.ready = in_ready;
  assign accept          = byte_chan.valid && in_ready;

  usd_lead_decode u_lead (
    .byte_in (byte_chan.byte_in),
    .lead    (lead)
  );

  usd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .byte_in (byte_chan.byte_in),
    .lead    (lead),
    .res     (res)
  );

  usd_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .in_ready  (in_ready),
    .item_chan (item_chan)
  );

endmodule
